// ----- rtl/stlb_pkg.sv -----
// ----------------------------------------------------------------------------
// stlb_pkg
// Shared types and codes for the set-associative TLB.
// ----------------------------------------------------------------------------
package stlb_pkg;

    localparam int VPN_W = 20;
    localparam int PPN_W = 20;

    typedef enum logic [1:0] {
        OP_READ       = 2'd0,
        OP_WRITE      = 2'd1,
        OP_FILL_READ  = 2'd2,
        OP_FILL_WRITE = 2'd3
    } t_op;

    // Classified command handed from the front to the back
    typedef struct packed {
        logic             is_fill;
        logic             is_write;
        logic [VPN_W-1:0] vpn;
        logic [PPN_W-1:0] ppn;
        logic             pte_dirty;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// ----- rtl/set_assoc_tlb_lru.sv -----
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru
// Set-associative TLB with true-LRU replacement and dirty tracking.
// ----------------------------------------------------------------------------
// Each request passes through the execute unit: in IDLE it reads the set row
// from the RAM, and in EXEC it updates the row, writes it back and registers
// the result, holding while an earlier result is unpopped; a two-entry queue
// in front lets new requests land while a result waits. After reset, full
// stays high as a clearing pass writes each set row. One result per request.
module set_assoc_tlb_lru #(
    parameter int SET_BITS = 4,
    parameter int WAYS     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [19:0] i_vpn,
    input  logic [19:0] i_fill_ppn,
    input  logic        i_pte_dirty,
    output logic        empty,
    input  logic        pop,
    output logic        o_hit,
    output logic [19:0] o_ppn_out,
    output logic [1:0]  o_way_out,
    output logic        o_mark_pte_dirty
);
    import stlb_pkg::*;

    logic w_cmd_valid;
    logic w_cmd_take;
    logic w_clearing;
    t_cmd w_cmd;

    stlb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_operation (i_operation),
        .i_vpn       (i_vpn),
        .i_fill_ppn  (i_fill_ppn),
        .i_pte_dirty (i_pte_dirty),
        .i_block     (w_clearing),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    stlb_back #(.SET_BITS(SET_BITS), .WAYS(WAYS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (w_cmd_valid),
        .i_cmd            (w_cmd),
        .o_cmd_take       (w_cmd_take),
        .o_clearing       (w_clearing),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_hit            (o_hit),
        .o_ppn_out        (o_ppn_out),
        .o_way_out        (o_way_out),
        .o_mark_pte_dirty (o_mark_pte_dirty)
    );

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> full)
        else $error("request accepted during clearing pass");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without pop");

    a_mark_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_mark_pte_dirty) |-> o_hit)
        else $error("dirty mark without hit");
endmodule

// ----- rtl/stlb_ram.sv -----
// ----------------------------------------------------------------------------
// stlb_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module stlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/stlb_front.sv -----
// ----------------------------------------------------------------------------
// stlb_front
// Accepts requests, classifies the operation and queues them (two entries).
// ----------------------------------------------------------------------------
module stlb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [1:0]           i_operation,
    input  logic [19:0]          i_vpn,
    input  logic [19:0]          i_fill_ppn,
    input  logic                 i_pte_dirty,
    input  logic                 i_block,
    output logic                 o_cmd_valid,
    output stlb_pkg::t_cmd       o_cmd,
    input  logic                 i_cmd_take
);
    import stlb_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push_ok;
    logic       take_ok;
    t_cmd       new_cmd;
    t_op        op;

    assign op      = t_op'(i_operation);
    assign o_full  = (r_cnt == 2'd2) || i_block;
    assign push_ok = i_push && !o_full;
    assign take_ok = i_cmd_take && (r_cnt != 2'd0);

    always_comb begin
        new_cmd.is_fill   = (op == OP_FILL_READ) || (op == OP_FILL_WRITE);
        new_cmd.is_write  = (op == OP_WRITE) || (op == OP_FILL_WRITE);
        new_cmd.vpn       = i_vpn;
        new_cmd.ppn       = i_fill_ppn;
        new_cmd.pte_dirty = i_pte_dirty;
    end

    always_comb begin
        n_wp  = r_wp ^ push_ok;
        n_rp  = r_rp ^ take_ok;
        n_cnt = r_cnt + {1'b0, push_ok} - {1'b0, take_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= new_cmd;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
endmodule

// ----- rtl/stlb_back.sv -----
// ----------------------------------------------------------------------------
// stlb_back
// Executes lookups and fills: reads a set row, updates it, writes it back.
// ----------------------------------------------------------------------------
module stlb_back #(
    parameter int SET_BITS = 4,
    parameter int WAYS     = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  stlb_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    output logic           o_clearing,
    output logic           o_empty,
    input  logic           i_pop,
    output logic           o_hit,
    output logic [19:0]    o_ppn_out,
    output logic [1:0]     o_way_out,
    output logic           o_mark_pte_dirty
);
    import stlb_pkg::*;

    localparam int SETS   = 1 << SET_BITS;
    localparam int SET_W  = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W  = VPN_W - SET_BITS;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int E_W    = 1 + TAG_W + PPN_W + 1 + WAY_W;
    localparam int ROW_W  = WAYS * E_W;
    localparam int DIRTY_O = WAY_W;
    localparam int PAGE_O  = WAY_W + 1;
    localparam int TAG_O   = WAY_W + 1 + PPN_W;
    localparam int VALID_O = E_W - 1;

    t_state r_state, n_state;
    logic [SET_W-1:0] r_clr, n_clr;
    t_cmd   r_cmd;

    logic             ram_we, ram_re;
    logic [SET_W-1:0] ram_waddr, ram_raddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata;
    logic [ROW_W-1:0] reset_row, upd_row;

    logic             out_free;
    logic             load_out;
    logic             r_out_v;
    logic             r_hit, r_mark;
    logic [PPN_W-1:0] r_ppn;
    logic [1:0]       r_way;

    logic [SET_W-1:0] cmd_set, cur_set;
    logic [TAG_W-1:0] cur_tag;

    logic             found;
    logic [WAY_W-1:0] hit_way, vic_way, sel_way;
    logic [WAY_W-1:0] target;
    logic [PPN_W-1:0] res_ppn;
    logic [1:0]       res_way;

    stlb_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    if (SET_BITS > 0) begin : g_set
        assign cmd_set = i_cmd.vpn[SET_W-1:0];
        assign cur_set = r_cmd.vpn[SET_W-1:0];
    end else begin : g_noset
        assign cmd_set = '0;
        assign cur_set = '0;
    end
    assign cur_tag = r_cmd.vpn[VPN_W-1:SET_BITS];

    always_comb begin
        reset_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            reset_row[w*E_W +: WAY_W] = WAY_W'(WAYS - 1 - w);
        end
    end

    // Lookup, victim choice and LRU promotion on the row just read
    always_comb begin
        found   = 1'b0;
        hit_way = '0;
        vic_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (ram_rdata[w*E_W + VALID_O]
                && ram_rdata[w*E_W + TAG_O +: TAG_W] == cur_tag) begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (ram_rdata[w*E_W +: WAY_W] == WAY_W'(WAYS - 1)) begin
                vic_way = WAY_W'(w);
            end
        end
        sel_way = r_cmd.is_fill ? vic_way : hit_way;
        target  = ram_rdata[sel_way*E_W +: WAY_W];
        upd_row = ram_rdata;
        if (r_cmd.is_fill || found) begin
            for (int w = 0; w < WAYS; w++) begin
                if (ram_rdata[w*E_W +: WAY_W] < target) begin
                    upd_row[w*E_W +: WAY_W] = ram_rdata[w*E_W +: WAY_W] + 1'b1;
                end
            end
            upd_row[sel_way*E_W +: WAY_W] = '0;
            if (r_cmd.is_fill) begin
                upd_row[sel_way*E_W + VALID_O]         = 1'b1;
                upd_row[sel_way*E_W + TAG_O +: TAG_W]  = cur_tag;
                upd_row[sel_way*E_W + PAGE_O +: PPN_W] = r_cmd.ppn;
                upd_row[sel_way*E_W + DIRTY_O] = r_cmd.is_write | r_cmd.pte_dirty;
            end else if (r_cmd.is_write) begin
                upd_row[sel_way*E_W + DIRTY_O] = 1'b1;
            end
        end
        if (r_cmd.is_fill) begin
            res_ppn = r_cmd.ppn;
        end else if (found) begin
            res_ppn = ram_rdata[sel_way*E_W + PAGE_O +: PPN_W];
        end else begin
            res_ppn = '0;
        end
        res_way = (r_cmd.is_fill || found) ? 2'({2'b00, sel_way}) : 2'd0;
    end

    assign out_free = !r_out_v || i_pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == SET_W'(SETS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_cmd_valid) n_state = ST_EXEC;
            ST_EXEC:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = cur_set;
        ram_wdata  = upd_row;
        ram_re     = 1'b0;
        ram_raddr  = cmd_set;
        o_cmd_take = 1'b0;
        load_out   = 1'b0;
        n_clr      = r_clr;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = reset_row;
                n_clr     = r_clr + 1'b1;
            end
            ST_IDLE: begin
                ram_re     = i_cmd_valid;
                o_cmd_take = i_cmd_valid;
            end
            ST_EXEC: begin
                ram_we   = out_free;
                load_out = out_free;
            end
            default: begin
                n_clr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (load_out) begin
            r_hit  <= !r_cmd.is_fill && found;
            r_mark <= !r_cmd.is_fill && found && r_cmd.is_write;
            r_ppn  <= res_ppn;
            r_way  <= res_way;
        end
    end

    assign o_clearing       = (r_state == ST_CLEAR);
    assign o_empty          = !r_out_v;
    assign o_hit            = r_hit;
    assign o_ppn_out        = r_ppn;
    assign o_way_out        = r_way;
    assign o_mark_pte_dirty = r_mark;
endmodule
